/* hdl/tedc_pkg.sv */
// ----------------------------------------------------------------------------
// tedc_pkg: shared types and constants of the ebb duration calculator
// Fixed-point formats, CORDIC arctangent table, status codes, flag group.
// ----------------------------------------------------------------------------
package tedc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;

  // datapath widths
  localparam int Z_W    = 33;   // Q30 angle, signed
  localparam int ROT_W  = 33;   // rotation x/y, Q30 signed
  localparam int PROD_W = 50;   // amplitude times sine/cosine
  localparam int VEC_W  = 54;   // vectoring x/y, mm * 2^-30
  localparam int REM_W  = 63;   // minutes dividend
  localparam int DVS_W  = 54;   // minutes divisor
  localparam int QUO_W  = 14;   // minutes quotient bits before saturation
  localparam int PREP_LAT = 4;  // angle preparation stages

  localparam logic signed [Z_W-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [Z_W-1:0] GAIN_Q30    = 33'sd652032874;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FREQ_ZERO = 2'd1,
    ST_INDET     = 2'd2
  } status_t;

  typedef struct packed {
    logic ovf;    // quotient beyond the hour range
    logic fz;     // frequency zero
    logic indet;  // zero over zero in a ratio
  } flag_t;

  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/tedc_angle_prep.sv */
// ----------------------------------------------------------------------------
// tedc_angle_prep: phase reduction and conversion to Q30 radians
// Reduces modulo 36000, folds into +-9000 and scales by pi/18000.
// ----------------------------------------------------------------------------
module tedc_angle_prep #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [18:0]              theta,
  input  logic [SIDE_W-1:0]               side_in,
  output logic signed [tedc_pkg::Z_W-1:0] z,
  output logic                            flip,
  output logic [SIDE_W-1:0]               side_out
);

  logic signed [19:0] ts;
  logic [18:0] t, u1, u2, u3;
  logic [15:0] r0;
  logic [13:0] mag;
  logic        neg, flp;

  logic [13:0] mag1;
  logic        neg1, flip1;
  logic [SIDE_W-1:0] side1;

  logic [24:0] n2;
  logic [31:0] base2;
  logic        neg2, flip2;
  logic [SIDE_W-1:0] side2;

  logic [48:0] prod3;
  logic [11:0] q03;
  logic [24:0] n3;
  logic [31:0] base3;
  logic        neg3, flip3;
  logic [SIDE_W-1:0] side3;

  logic [24:0] rem4;
  logic [11:0] q4;
  logic [31:0] zm4;

  // reduce to [0, 36000) and fold into a quarter turn
  always_comb begin
    ts = {theta[18], theta} + 20'sd72000;
    t  = ts[18:0];
    u1 = (t  >= 19'd144000) ? t  - 19'd144000 : t;
    u2 = (u1 >= 19'd72000)  ? u1 - 19'd72000  : u1;
    u3 = (u2 >= 19'd36000)  ? u2 - 19'd36000  : u2;
    r0 = u3[15:0];
    if (r0 <= 16'd9000) begin
      mag = r0[13:0];
      neg = 1'b0;
      flp = 1'b0;
    end else if (r0 <= 16'd18000) begin
      mag = 14'(16'd18000 - r0);
      neg = (r0 != 16'd18000);
      flp = 1'b1;
    end else if (r0 < 16'd27000) begin
      mag = 14'(r0 - 16'd18000);
      neg = 1'b0;
      flp = 1'b1;
    end else begin
      mag = 14'(16'd36000 - r0);
      neg = 1'b1;
      flp = 1'b0;
    end
  end

  // pi/18000 = 187403 + 2713/9000 in Q30
  assign prod3 = 49'(n2) * 49'd15270994;

  always_comb begin
    rem4 = n3 - 25'(q03) * 25'd9000;
    q4   = q03 + 12'(rem4 >= 25'd9000);
    zm4  = base3 + 32'(q4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag;
      neg1  <= neg;
      flip1 <= flp;
      side1 <= side_in;

      n2    <= 25'(mag1) * 25'd2713;
      base2 <= 32'(mag1) * 32'd187403;
      neg2  <= neg1;
      flip2 <= flip1;
      side2 <= side1;

      q03   <= prod3[48:37];
      n3    <= n2;
      base3 <= base2;
      neg3  <= neg2;
      flip3 <= flip2;
      side3 <= side2;

      z        <= neg3 ? -$signed({1'b0, zm4}) : $signed({1'b0, zm4});
      flip     <= flip3;
      side_out <= side3;
    end
  end

endmodule

/* hdl/tedc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// tedc_cordic_cell: one registered CORDIC micro-rotation
// Rotation mode steers by the sign of z, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module tedc_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0,
  parameter int XY_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [XY_W-1:0]          x_in,
  input  logic signed [XY_W-1:0]          y_in,
  input  logic signed [tedc_pkg::Z_W-1:0] z_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic signed [XY_W-1:0]          x_out,
  output logic signed [XY_W-1:0]          y_out,
  output logic signed [tedc_pkg::Z_W-1:0] z_out,
  output logic [SIDE_W-1:0]               side_out
);

  logic signed [XY_W-1:0] dx, dy, x_nx, y_nx;
  logic signed [tedc_pkg::Z_W-1:0] ang, z_nx;
  logic pos;

  assign dx  = y_in >>> STAGE;
  assign dy  = x_in >>> STAGE;
  assign ang = $signed({3'b000, tedc_pkg::atan_q30(STAGE)});

  always_comb begin
    if (VECTOR) begin
      pos = ~y_in[XY_W-1];
      if (pos) begin
        x_nx = x_in + dx;
        y_nx = y_in - dy;
        z_nx = z_in + ang;
      end else begin
        x_nx = x_in - dx;
        y_nx = y_in + dy;
        z_nx = z_in - ang;
      end
    end else begin
      pos = ~z_in[tedc_pkg::Z_W-1];
      if (pos) begin
        x_nx = x_in - dx;
        y_nx = y_in + dy;
        z_nx = z_in - ang;
      end else begin
        x_nx = x_in + dx;
        y_nx = y_in - dy;
        z_nx = z_in + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_nx;
      y_out    <= y_nx;
      z_out    <= z_nx;
      side_out <= side_in;
    end
  end

endmodule

/* hdl/tedc_div_cell.sv */
// ----------------------------------------------------------------------------
// tedc_div_cell: one registered restoring division step
// Resolves one quotient bit of the minutes count.
// ----------------------------------------------------------------------------
module tedc_div_cell #(
  parameter int BIT = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tedc_pkg::REM_W-1:0]        rem_in,
  input  logic [tedc_pkg::DVS_W-1:0]        dvs_in,
  input  logic [tedc_pkg::QUO_W-1:0]        quo_in,
  input  tedc_pkg::flag_t                   flags_in,
  output logic [tedc_pkg::REM_W-1:0]        rem_out,
  output logic [tedc_pkg::DVS_W-1:0]        dvs_out,
  output logic [tedc_pkg::QUO_W-1:0]        quo_out,
  output tedc_pkg::flag_t                   flags_out
);

  localparam int CMP_W = tedc_pkg::DVS_W + tedc_pkg::QUO_W;

  logic [CMP_W-1:0] sh, rem_e, diff;
  logic ge;

  assign sh    = CMP_W'(dvs_in) << BIT;
  assign rem_e = CMP_W'(rem_in);
  assign ge    = (rem_e >= sh);
  assign diff  = rem_e - sh;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out   <= ge ? diff[tedc_pkg::REM_W-1:0] : rem_in;
      dvs_out   <= dvs_in;
      quo_out   <= {quo_in[tedc_pkg::QUO_W-2:0], ge};
      flags_out <= flags_in;
    end
  end

endmodule

/* hdl/tide_ebb_duration_calc_core.sv */
// ----------------------------------------------------------------------------
// tide_ebb_duration_calc_core: ebb duration from the M2, M4 and M6 constituents
// Fully pipelined: angle prep, rotation CORDIC rows, products, vectoring
// CORDIC rows, scaling, restoring divider row, hour/minute split.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (lsb first)                          | bits
//  --------+-----+---------------------------------------------------+-----
//  s_*     | in  | amp_m2 amp_m4 amp_m6 phase_m2 phase_m4 phase_m6   | 120
//          |     | freq_m2 (22), zero pad                            |
//  m_*     | out | ebb_hours (8) ebb_minutes (6) status (2)          | 16
//
//  One request per cycle while the output can load or the last stage is empty.
//  Stages from the input accept to m_tvalid: 4 prep, two CORDIC rows of
//  CORDIC_STAGES cells, 3 product, 3 scaling, 14 divider, 1 split, 1 output.
//  rst is synchronous and clears only the valid bits and the output valid.
//  A stalled output holds; the pipe keeps moving while its last stage is
//  empty, so bubbles are squeezed out before s_tready drops.
// ----------------------------------------------------------------------------
module tide_ebb_duration_calc_core #(
  parameter int CORDIC_STAGES = tedc_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // amp_m2[15:0] amp_m4[31:16] amp_m6[47:32] phase_m2[63:48]
  // phase_m4[79:64] phase_m6[95:80] freq_m2[117:96], zero pad [119:118]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // ebb_hours[7:0] ebb_minutes[13:8] status[15:14]
  output logic [15:0]  m_tdata
);

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = tedc_pkg::PREP_LAT + 2 * N + 7 + tedc_pkg::QUO_W;
  localparam int ROT = tedc_pkg::ROT_W;
  localparam int VW  = tedc_pkg::VEC_W;
  localparam int ZW  = tedc_pkg::Z_W;
  localparam int QW  = tedc_pkg::QUO_W;

  // ---- handshake: advance when the output can load or the tail is empty
  logic           en, out_load;
  logic [LAT-1:0] vld;

  assign out_load = ~m_tvalid | m_tready;
  assign en       = out_load | ~vld[LAT-1];
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // ---- unpack the request
  logic [15:0] amp_m2, amp_m4, amp_m6, phase_m2, phase_m4, phase_m6;
  logic [21:0] freq_m2;
  logic signed [18:0] th1, th2;

  assign amp_m2   = s_tdata[15:0];
  assign amp_m4   = s_tdata[31:16];
  assign amp_m6   = s_tdata[47:32];
  assign phase_m2 = s_tdata[63:48];
  assign phase_m4 = s_tdata[79:64];
  assign phase_m6 = s_tdata[95:80];
  assign freq_m2  = s_tdata[117:96];

  // th1 = 2*p2 - p4, th2 = 3*p2 - p6
  assign th1 = $signed({2'b00, phase_m2, 1'b0}) - $signed({3'b000, phase_m4});
  assign th2 = $signed({2'b00, phase_m2, 1'b0}) + $signed({3'b000, phase_m2})
             - $signed({3'b000, phase_m6});

  // ---- angle preparation; amplitudes and frequency ride alongside
  logic signed [ZW-1:0] z1p, z2p;
  logic                 flip1p, flip2p;
  logic [53:0]          side1p;
  logic [15:0]          side2p;

  tedc_angle_prep #(.SIDE_W(54)) u_prep1 (
    .clk(clk), .en(en), .theta(th1), .side_in({amp_m2, amp_m4, freq_m2}),
    .z(z1p), .flip(flip1p), .side_out(side1p)
  );

  tedc_angle_prep #(.SIDE_W(16)) u_prep2 (
    .clk(clk), .en(en), .theta(th2), .side_in(amp_m6),
    .z(z2p), .flip(flip2p), .side_out(side2p)
  );

  // ---- rotation rows: sin/cos of th1 and th2
  logic signed [ROT-1:0] r1x [0:N];
  logic signed [ROT-1:0] r1y [0:N];
  logic signed [ZW-1:0]  r1z [0:N];
  logic [54:0]           r1s [0:N];
  logic signed [ROT-1:0] r2x [0:N];
  logic signed [ROT-1:0] r2y [0:N];
  logic signed [ZW-1:0]  r2z [0:N];
  logic [16:0]           r2s [0:N];

  assign r1x[0] = tedc_pkg::GAIN_Q30;
  assign r1y[0] = '0;
  assign r1z[0] = z1p;
  assign r1s[0] = {side1p, flip1p};
  assign r2x[0] = tedc_pkg::GAIN_Q30;
  assign r2y[0] = '0;
  assign r2z[0] = z2p;
  assign r2s[0] = {side2p, flip2p};

  for (genvar i = 0; i < N; i++) begin : g_rot
    tedc_cordic_cell #(.STAGE(i), .VECTOR(1'b0), .XY_W(ROT), .SIDE_W(55)) u_r1 (
      .clk(clk), .en(en),
      .x_in(r1x[i]), .y_in(r1y[i]), .z_in(r1z[i]), .side_in(r1s[i]),
      .x_out(r1x[i+1]), .y_out(r1y[i+1]), .z_out(r1z[i+1]), .side_out(r1s[i+1])
    );
    tedc_cordic_cell #(.STAGE(i), .VECTOR(1'b0), .XY_W(ROT), .SIDE_W(17)) u_r2 (
      .clk(clk), .en(en),
      .x_in(r2x[i]), .y_in(r2y[i]), .z_in(r2z[i]), .side_in(r2s[i]),
      .x_out(r2x[i+1]), .y_out(r2y[i+1]), .z_out(r2z[i+1]), .side_out(r2s[i+1])
    );
  end

  // ---- M1: undo the fold and multiply by the amplitudes
  logic signed [ROT-1:0] s1, c1, s2, c2;
  logic [15:0] a2_r, a4_r, a6_r;
  logic [21:0] fq_r;

  assign a2_r = r1s[N][54:39];
  assign a4_r = r1s[N][38:23];
  assign fq_r = r1s[N][22:1];
  assign a6_r = r2s[N][16:1];
  assign s1 = r1s[N][0] ? -r1y[N] : r1y[N];
  assign c1 = r1s[N][0] ? -r1x[N] : r1x[N];
  assign s2 = r2s[N][0] ? -r2y[N] : r2y[N];
  assign c2 = r2s[N][0] ? -r2x[N] : r2x[N];

  logic signed [tedc_pkg::PROD_W-1:0] pa, pb, pc, pd;
  logic [15:0] a2_m1;
  logic [21:0] fq_m1;

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= $signed({1'b0, a4_r}) * s1;
      pc    <= $signed({1'b0, a4_r}) * c1;
      pb    <= $signed({1'b0, a6_r}) * s2;
      pd    <= $signed({1'b0, a6_r}) * c2;
      a2_m1 <= a2_r;
      fq_m1 <= fq_r;
    end
  end

  // ---- M2: a, b, c, d and the two ratios
  logic signed [VW-1:0] pa_e, pb_e, pc_e, pd_e, ta, tb, tc, td;
  logic signed [VW-1:0] num_v, den_v, num_w, den_w;
  logic [21:0] fq_m2;

  assign pa_e = {{(VW-tedc_pkg::PROD_W){pa[tedc_pkg::PROD_W-1]}}, pa};
  assign pb_e = {{(VW-tedc_pkg::PROD_W){pb[tedc_pkg::PROD_W-1]}}, pb};
  assign pc_e = {{(VW-tedc_pkg::PROD_W){pc[tedc_pkg::PROD_W-1]}}, pc};
  assign pd_e = {{(VW-tedc_pkg::PROD_W){pd[tedc_pkg::PROD_W-1]}}, pd};
  assign ta = pa_e <<< 1;
  assign tb = (pb_e <<< 1) + pb_e;
  assign tc = pc_e <<< 2;
  assign td = (pd_e <<< 3) + pd_e + $signed({{(VW-46){1'b0}}, a2_m1, 30'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      num_v <= ta + tb;
      den_v <= tc + td;
      num_w <= ta - tb;
      den_w <= tc - td;
      fq_m2 <= fq_m1;
    end
  end

  // ---- M3: flag zero denominators, make denominators positive
  logic signed [VW-1:0] vx0, vy0, wx0, wy0;
  logic [2:0]  fl_v, fl_w;   // {den zero, num zero, num negative}
  logic [21:0] fq_m3;

  always_ff @(posedge clk) begin
    if (en) begin
      vx0   <= den_v[VW-1] ? -den_v : den_v;
      vy0   <= den_v[VW-1] ? -num_v : num_v;
      wx0   <= den_w[VW-1] ? -den_w : den_w;
      wy0   <= den_w[VW-1] ? -num_w : num_w;
      fl_v  <= {den_v == '0, num_v == '0, num_v[VW-1]};
      fl_w  <= {den_w == '0, num_w == '0, num_w[VW-1]};
      fq_m3 <= fq_m2;
    end
  end

  // ---- vectoring rows: v and w
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic signed [ZW-1:0] vz [0:N];
  logic [24:0]          vs [0:N];
  logic signed [VW-1:0] wx [0:N];
  logic signed [VW-1:0] wy [0:N];
  logic signed [ZW-1:0] wz [0:N];
  logic [2:0]           ws [0:N];

  assign vx[0] = vx0;
  assign vy[0] = vy0;
  assign vz[0] = '0;
  assign vs[0] = {fq_m3, fl_v};
  assign wx[0] = wx0;
  assign wy[0] = wy0;
  assign wz[0] = '0;
  assign ws[0] = fl_w;

  for (genvar i = 0; i < N; i++) begin : g_vec
    tedc_cordic_cell #(.STAGE(i), .VECTOR(1'b1), .XY_W(VW), .SIDE_W(25)) u_v (
      .clk(clk), .en(en),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]), .side_in(vs[i]),
      .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]), .side_out(vs[i+1])
    );
    tedc_cordic_cell #(.STAGE(i), .VECTOR(1'b1), .XY_W(VW), .SIDE_W(3)) u_w (
      .clk(clk), .en(en),
      .x_in(wx[i]), .y_in(wy[i]), .z_in(wz[i]), .side_in(ws[i]),
      .x_out(wx[i+1]), .y_out(wy[i+1]), .z_out(wz[i+1]), .side_out(ws[i+1])
    );
  end

  // ---- V1: clamp, handle zero denominators, D = pi + v - w
  logic signed [ZW-1:0] v_ang, w_ang, vcl, wcl;
  logic signed [ZW+1:0] dsum;
  logic [32:0] d_v1;
  logic [21:0] fq_v1;
  logic        indet_v1;

  always_comb begin
    vcl = vz[N];
    if (vcl > tedc_pkg::HALF_PI_Q30) vcl = tedc_pkg::HALF_PI_Q30;
    if (vcl < -tedc_pkg::HALF_PI_Q30) vcl = -tedc_pkg::HALF_PI_Q30;
    wcl = wz[N];
    if (wcl > tedc_pkg::HALF_PI_Q30) wcl = tedc_pkg::HALF_PI_Q30;
    if (wcl < -tedc_pkg::HALF_PI_Q30) wcl = -tedc_pkg::HALF_PI_Q30;
    if (vs[N][2]) begin
      v_ang = vs[N][0] ? -tedc_pkg::HALF_PI_Q30 : tedc_pkg::HALF_PI_Q30;
    end else begin
      v_ang = vcl;
    end
    if (ws[N][2]) begin
      w_ang = ws[N][0] ? -tedc_pkg::HALF_PI_Q30 : tedc_pkg::HALF_PI_Q30;
    end else begin
      w_ang = wcl;
    end
    dsum = {2'b00, tedc_pkg::PI_Q30} + {{2{v_ang[ZW-1]}}, v_ang}
         - {{2{w_ang[ZW-1]}}, w_ang};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_v1     <= dsum[32:0];
      fq_v1    <= vs[N][24:3];
      indet_v1 <= (vs[N][2] & vs[N][1]) | (ws[N][2] & ws[N][1]);
    end
  end

  // ---- V2: dividend D*10800*65536, divisor pi*freq
  logic [tedc_pkg::REM_W-1:0] nn_v2;
  logic [tedc_pkg::DVS_W-1:0] dd_v2;
  logic fz_v2, indet_v2;

  always_ff @(posedge clk) begin
    if (en) begin
      nn_v2    <= tedc_pkg::REM_W'(d_v1) * 63'd707788800;
      dd_v2    <= tedc_pkg::DVS_W'(fq_v1) * 54'd3373259426;
      fz_v2    <= (fq_v1 == '0);
      indet_v2 <= indet_v1;
    end
  end

  // ---- V3: catch a quotient past the 14-bit range
  logic [tedc_pkg::REM_W-1:0] dr [0:QW];
  logic [tedc_pkg::DVS_W-1:0] dd [0:QW];
  logic [QW-1:0]              dq [0:QW];
  tedc_pkg::flag_t            df [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]       <= nn_v2;
      dd[0]       <= dd_v2;
      dq[0]       <= '0;
      df[0].ovf   <= ({5'b0, nn_v2} >= {dd_v2, {QW{1'b0}}});
      df[0].fz    <= fz_v2;
      df[0].indet <= indet_v2;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    tedc_div_cell #(.BIT(QW - 1 - k)) u_div (
      .clk(clk), .en(en),
      .rem_in(dr[k]), .dvs_in(dd[k]), .quo_in(dq[k]), .flags_in(df[k]),
      .rem_out(dr[k+1]), .dvs_out(dd[k+1]), .quo_out(dq[k+1]), .flags_out(df[k+1])
    );
  end

  // ---- F1: estimate minutes/60 by reciprocal
  logic [28:0]     recip;
  logic [QW-1:0]   m_f1;
  logic [8:0]      q0_f1;
  tedc_pkg::flag_t fl_f1;

  assign recip = 29'(dq[QW]) * 29'd17476;

  always_ff @(posedge clk) begin
    if (en) begin
      m_f1  <= dq[QW];
      q0_f1 <= recip[28:20];
      fl_f1 <= df[QW];
    end
  end

  // ---- split into hours and minutes, saturate, pick the status
  logic [QW-1:0] rem_f;
  logic [8:0]    hrs;
  logic [5:0]    mns;
  logic [7:0]    hrs_o;
  logic [5:0]    mns_o;
  tedc_pkg::status_t st;

  always_comb begin
    rem_f = m_f1 - QW'(q0_f1) * 14'd60;
    if (rem_f >= 14'd60) begin
      hrs = q0_f1 + 9'd1;
      mns = 6'(rem_f - 14'd60);
    end else begin
      hrs = q0_f1;
      mns = rem_f[5:0];
    end
    if (fl_f1.fz) begin
      st    = tedc_pkg::ST_FREQ_ZERO;
      hrs_o = '0;
      mns_o = '0;
    end else if (fl_f1.indet) begin
      st    = tedc_pkg::ST_INDET;
      hrs_o = '0;
      mns_o = '0;
    end else if (fl_f1.ovf || hrs > 9'd255) begin
      st    = tedc_pkg::ST_OK;
      hrs_o = 8'd255;
      mns_o = 6'd59;
    end else begin
      st    = tedc_pkg::ST_OK;
      hrs_o = hrs[7:0];
      mns_o = mns;
    end
  end

  // ---- output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {st, mns_o, hrs_o};
    end
  end

endmodule
